[design/crc32nt_pkg.sv]
// ----------------------------------------------------------------------------
// crc32nt_pkg
// Shared constants and the nibble fold step for the nibble-table CRC stream.
// ----------------------------------------------------------------------------
package crc32nt_pkg;

  localparam int unsigned CRC_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIB_W  = 4;

  localparam logic [CRC_W-1:0] CRC_INIT = '1;

  // reflected 0xEDB88320, one entry per nibble value
  localparam logic [CRC_W-1:0] NIB_TAB [16] = '{
    32'h0000_0000, 32'h1db7_1064, 32'h3b6e_20c8, 32'h26d9_30ac,
    32'h76dc_4190, 32'h6b6b_51f4, 32'h4db2_6158, 32'h5005_713c,
    32'hedb8_8320, 32'hf00f_9344, 32'hd6d6_a3e8, 32'hcb61_b38c,
    32'h9b64_c2b0, 32'h86d3_d2d4, 32'ha00a_e278, 32'hbdbd_f21c
  };

  function automatic logic [CRC_W-1:0] fold_nibble(
    input logic [CRC_W-1:0] c,
    input logic [NIB_W-1:0] nib
  );
    logic [NIB_W-1:0] idx;
    idx = c[NIB_W-1:0] ^ nib;
    return NIB_TAB[idx] ^ (c >> NIB_W);
  endfunction

endpackage

[design/crc32_nibble_table_stream.sv]
// ----------------------------------------------------------------------------
// crc32_nibble_table_stream
// Streaming nibble-table CRC (poly 0xEDB88320, inverted after every byte).
// ----------------------------------------------------------------------------
// Input channel: data_byte, first_byte, last_byte with in_valid / in_stall.
// A beat is taken on a clock edge with in_valid high and in_stall low.
// first_byte reloads all ones before the byte is folded in; last_byte is
// echoed on is_last with the final record CRC.
// Output channel: crc_value, is_last with out_valid / out_stall; one result
// beat per input beat, in order.
// Path: a byte passes the input register, then the result register, before
// out_valid rises. Throughput: one byte per cycle while out_stall is low;
// the two table lookups feed the running CRC register combinationally.
// When the receiver stalls, the result register holds and the input
// register keeps one more byte, after which in_stall rises.
// Reset (rst, synchronous) empties both registers and sets the running CRC
// to all ones, so the first record needs no first_byte.
// ----------------------------------------------------------------------------
module crc32_nibble_table_stream (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crc32nt_pkg::BYTE_W-1:0] data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crc32nt_pkg::CRC_W-1:0]  crc_value,
  output logic                           is_last
);

  logic                           held;
  logic [crc32nt_pkg::BYTE_W-1:0] held_data;
  logic                           held_first;
  logic                           held_last;
  logic                           advance;
  logic [crc32nt_pkg::CRC_W-1:0]  running_crc;
  logic [crc32nt_pkg::CRC_W-1:0]  running_crc_next;

  // held beat moves to the result register when that one is free or leaving
  assign advance = held && (!out_valid || !out_stall);

  crc32nt_stage u_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .take       (advance),
    .held       (held),
    .held_data  (held_data),
    .held_first (held_first),
    .held_last  (held_last)
  );

  crc32nt_fold u_fold (
    .crc_in     (running_crc),
    .data_byte  (held_data),
    .first_byte (held_first),
    .crc_out    (running_crc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= crc32nt_pkg::CRC_INIT;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        running_crc <= running_crc_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_value <= running_crc_next;
      is_last   <= held_last;
    end
  end

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid && !held)
    else $error("result or input register not empty after reset");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(running_crc))
    else $error("running CRC changed without a beat advancing");

  a_out_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> crc_value == running_crc)
    else $error("result beat does not match running CRC");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (held && out_valid && out_stall) |-> in_stall)
    else $error("input taken while both registers are full and stalled");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !held) |=> !out_valid)
    else $error("result beat repeated after being taken");

endmodule

[design/crc32nt_fold.sv]
// ----------------------------------------------------------------------------
// crc32nt_fold
// One byte of CRC update: optional reload, low nibble, high nibble, invert.
// ----------------------------------------------------------------------------
module crc32nt_fold (
  input  logic [crc32nt_pkg::CRC_W-1:0]  crc_in,
  input  logic [crc32nt_pkg::BYTE_W-1:0] data_byte,
  input  logic                           first_byte,
  output logic [crc32nt_pkg::CRC_W-1:0]  crc_out
);

  logic [crc32nt_pkg::CRC_W-1:0] seed;
  logic [crc32nt_pkg::CRC_W-1:0] lo_fold;
  logic [crc32nt_pkg::CRC_W-1:0] hi_fold;

  assign seed    = first_byte ? crc32nt_pkg::CRC_INIT : crc_in;
  assign lo_fold = crc32nt_pkg::fold_nibble(seed, data_byte[3:0]);
  assign hi_fold = crc32nt_pkg::fold_nibble(lo_fold, data_byte[7:4]);
  // per-byte complement is part of the running value, not just the output
  assign crc_out = ~hi_fold;

endmodule

[design/crc32nt_stage.sv]
// ----------------------------------------------------------------------------
// crc32nt_stage
// Input register for one byte beat, with its own valid and stall handshake.
// ----------------------------------------------------------------------------
module crc32nt_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crc32nt_pkg::BYTE_W-1:0] data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  input  logic                           take,
  output logic                           held,
  output logic [crc32nt_pkg::BYTE_W-1:0] held_data,
  output logic                           held_first,
  output logic                           held_last
);

  logic load;

  // room when empty or the held beat leaves this cycle
  assign in_stall = held && !take;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_data  <= data_byte;
      held_first <= first_byte;
      held_last  <= last_byte;
    end
  end

endmodule

[tb/crc_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc_stream_checker
// Watches both channels of the nibble CRC stream, predicts each result beat
// with a bitwise reflected CRC model and compares it field by field.
// ----------------------------------------------------------------------------
module crc_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [crc32nt_pkg::BYTE_W-1:0] data_byte,
  input  logic                           first_byte,
  input  logic                           last_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [crc32nt_pkg::CRC_W-1:0]  crc_value,
  input  logic                           is_last,
  output int                             fail_count,
  output int                             outstanding
);

  localparam logic [31:0] POLY_REFL = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] crc;
    logic        last;
  } crc_beat_t;

  crc_beat_t   crc_expected_q[$];
  logic [31:0] record_crc;
  int          errors;

  // bit-serial LSB-first update, four shifts per nibble; low nibble goes first
  function automatic logic [31:0] crc_after_byte(input logic [31:0] c,
                                                 input logic [7:0]  b);
    logic [31:0] r;
    r = c ^ {28'h0, b[3:0]};
    repeat (4) r = r[0] ? ((r >> 1) ^ POLY_REFL) : (r >> 1);
    r = r ^ {28'h0, b[7:4]};
    repeat (4) r = r[0] ? ((r >> 1) ^ POLY_REFL) : (r >> 1);
    return ~r;
  endfunction

  initial begin
    record_crc  = ALL_ONES;
    errors      = 0;
  end

  always @(posedge clk) begin
    crc_beat_t want;
    if (rst) begin
      record_crc = ALL_ONES;
      crc_expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (first_byte) record_crc = ALL_ONES;
        record_crc = crc_after_byte(record_crc, data_byte);
        crc_expected_q.push_back({record_crc, last_byte});
      end
      if (out_valid && !out_stall) begin
        if (crc_expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: crc=%08h last=%0b", crc_value, is_last);
        end else begin
          want = crc_expected_q.pop_front();
          if (crc_value !== want.crc || is_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: exp crc=%08h last=%0b, got crc=%08h last=%0b",
                       want.crc, want.last, crc_value, is_last);
          end
        end
      end
    end
    fail_count  <= errors;
    outstanding <= crc_expected_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives byte records into the nibble CRC stream with random gaps and
// receiver stalls, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int RANDOM_BYTES = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           in_valid   = 1'b0;
  logic                           in_stall;
  logic [crc32nt_pkg::BYTE_W-1:0] data_byte  = '0;
  logic                           first_byte = 1'b0;
  logic                           last_byte  = 1'b0;
  logic                           out_valid;
  logic                           out_stall  = 1'b0;
  logic [crc32nt_pkg::CRC_W-1:0]  crc_value;
  logic                           is_last;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  bit steady_tx   = 1'b0;
  bit steady_rx   = 1'b0;
  bit want_hold   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  crc32_nibble_table_stream dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .crc_value  (crc_value),
    .is_last    (is_last)
  );

  crc_stream_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .crc_value   (crc_value),
    .is_last     (is_last),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // mostly short idles, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    int gap;
    gap = steady_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= f;
    last_byte  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_record(input int len, input bit with_first);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), with_first && (i == 0), i == len - 1);
  endtask

  // receiver: random stalls, steady stretches, and the requested long hold
  initial begin
    int run;
    forever begin
      if (want_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        want_hold = 1'b0;
      end else if (!steady_rx && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = idle_len();
        if (run == 0) run = 1;
        repeat (run) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = steady_rx ? 40 : $urandom_range(1, 4);
      repeat (run) @(posedge clk);
      steady_rx = ($urandom_range(0, 19) == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int  sent;
    int  len;
    int  mode;
    bit  hold_done;
    hold_done = 1'b0;
    sent      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // first record relies on the reset value, no first flag
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b0, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b1);
    // next record carries on from the previous final value
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    // one-beat records
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // reload in the middle of an open record
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h56, 1'b1, 1'b0);
    send_byte(8'h78, 1'b0, 1'b1);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1);

    while (sent < RANDOM_BYTES) begin
      steady_tx = ($urandom_range(0, 9) == 0);
      len = $urandom_range(1, 16);
      if (sent >= 600 && !hold_done) begin
        // back-to-back beats while the receiver holds off
        hold_done = 1'b1;
        want_hold = 1'b1;
        steady_tx = 1'b1;
        len       = 16;
      end
      mode = $urandom_range(0, 99);
      if (mode < 80) begin
        send_record(len, 1'b1);
      end else if (mode < 88) begin
        send_record(len, 1'b0);
      end else begin
        for (int i = 0; i < len; i++)
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end
      sent += len;
    end
    steady_tx = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
